// File: rtl/t2i_pkg.sv
package t2i_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_W       = 8;
    localparam int DIGIT_W     = 4;
    localparam int COUNT_W     = 5;
    localparam int VALUE_W     = 32;

    // Parser phases.
    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd1;
    localparam logic [1:0] REG_SYMBOL_COUNT = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;

    typedef struct packed {
        logic                 ok;
        logic                 hit;
        logic [DIGIT_W-1:0]   digit;
    } alpha_t;

    function automatic logic is_space(input logic [SYM_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) ||
               (c == CH_VT) || (c == CH_CR) || (c == CH_FF);
    endfunction

endpackage

// File: rtl/text_to_integer_any_base_top.sv
// Text to integer converter with a programmable digit alphabet.
// The s_ channel takes one character per word (s_tdata) with s_tlast marking
// the final character of a string. Leading whitespace is skipped, then a run
// of '+' and '-' signs sets the sign, then digits accumulate until the first
// character outside the alphabet. The word carrying s_tlast yields one result
// word on the m_ channel: m_tdata is the signed 32-bit value (wrapping on
// overflow), m_tuser flags a valid alphabet; with an invalid alphabet the
// value is zero. Other characters yield no result.
// The alphabet is set through the cfg_ port: index 0 holds symbols 0 to 7,
// index 1 symbols 8 to 15, index 2 the symbol count (the base). Write it only
// while no string is in flight.
// Throughput is one character per cycle, except that a last character waits
// while the result register is full. The input register feeds the lookup,
// multiply by the base and add, which lands in the parser state and result register.
// When the receiver stalls, the result register holds its word; characters
// that are not last keep flowing, and a last character waits in the input
// register until the result register frees up.
// Reset clears all valid flags, the parser state and the alphabet registers.
module text_to_integer_any_base_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [0:0]  m_tuser,   // [0] alphabet_ok
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]                   sym_low_reg;
    logic [63:0]                   sym_high_reg;
    logic [t2i_pkg::COUNT_W-1:0]   count_reg;

    logic                          in_valid_reg;
    logic [7:0]                    in_ch_reg;
    logic                          in_last_reg;

    logic [1:0]                    phase_reg, phase_next;
    logic                          par_reg, par_next;
    logic [t2i_pkg::VALUE_W-1:0]   acc_reg, acc_next;

    logic                          out_valid_reg;
    logic [t2i_pkg::VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                          out_ok_reg;

    logic                          consume;
    logic [t2i_pkg::VALUE_W-1:0]   prod;
    t2i_pkg::alpha_t               alpha;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
            count_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                t2i_pkg::REG_SYMBOLS_LOW:  sym_low_reg  <= cfg_data;
                t2i_pkg::REG_SYMBOLS_HIGH: sym_high_reg <= cfg_data;
                t2i_pkg::REG_SYMBOL_COUNT: count_reg    <= cfg_data[t2i_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    t2i_alpha u_alpha (
        .symbols_low  (sym_low_reg),
        .symbols_high (sym_high_reg),
        .symbol_count (count_reg),
        .ch           (in_ch_reg),
        .result       (alpha)
    );

    // A last character needs the result register; others can always move on.
    assign consume  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    assign prod = acc_reg * t2i_pkg::VALUE_W'(count_reg);

    always_comb begin
        phase_next = phase_reg;
        par_next   = par_reg;
        acc_next   = acc_reg;
        if ((phase_next == t2i_pkg::PH_SPACE) && !t2i_pkg::is_space(in_ch_reg)) begin
            phase_next = t2i_pkg::PH_SIGN;
        end
        if (phase_next == t2i_pkg::PH_SIGN) begin
            if (in_ch_reg == t2i_pkg::CH_MINUS) begin
                par_next = !par_reg;
            end else if (in_ch_reg != t2i_pkg::CH_PLUS) begin
                phase_next = t2i_pkg::PH_DIGIT;
            end
        end
        if (phase_next == t2i_pkg::PH_DIGIT) begin
            if (!alpha.hit) begin
                phase_next = t2i_pkg::PH_STOP;
            end else begin
                acc_next = prod + 32'(alpha.digit);
            end
        end
        if (!alpha.ok) begin
            out_value_next = '0;
        end else if (par_next) begin
            out_value_next = 32'd0 - acc_next;
        end else begin
            out_value_next = acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= t2i_pkg::PH_SPACE;
            par_reg   <= 1'b0;
            acc_reg   <= '0;
        end else if (consume) begin
            if (in_last_reg) begin
                phase_reg <= t2i_pkg::PH_SPACE;
                par_reg   <= 1'b0;
                acc_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                par_reg   <= par_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (consume && in_last_reg) begin
            out_value_reg <= out_value_next;
            out_ok_reg    <= alpha.ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_ok_reg;

`ifndef ASSERT_OFF
    a_bad_alpha_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("result with invalid alphabet carries a nonzero value");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |=>
            ((phase_reg == t2i_pkg::PH_SPACE) && !par_reg && (acc_reg == '0)))
        else $error("parser state not cleared after the last character");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result word appeared without a last character");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && out_valid_reg && !m_tready) |-> !consume)
        else $error("last character processed while result register is full");
`endif

endmodule

// File: rtl/t2i_alpha.sv
// Alphabet checks: digit lookup of one character and validity of the alphabet.
module t2i_alpha (
    input  logic [63:0]                    symbols_low,
    input  logic [63:0]                    symbols_high,
    input  logic [t2i_pkg::COUNT_W-1:0]    symbol_count,
    input  logic [t2i_pkg::SYM_W-1:0]      ch,
    output t2i_pkg::alpha_t                result
);

    logic [t2i_pkg::SYM_W-1:0]   sym [t2i_pkg::MAX_SYMBOLS];
    logic [t2i_pkg::COUNT_W-1:0] used;
    logic                        bad;
    logic                        hit;
    logic [t2i_pkg::DIGIT_W-1:0] digit;
    logic                        ok;

    always_comb begin
        for (int i = 0; i < t2i_pkg::MAX_SYMBOLS; i++) begin
            if (i < 8) begin
                sym[i] = symbols_low[8*i +: 8];
            end else begin
                sym[i] = symbols_high[8*(i-8) +: 8];
            end
        end
    end

    assign used = (symbol_count > t2i_pkg::COUNT_W'(t2i_pkg::MAX_SYMBOLS)) ?
                  t2i_pkg::COUNT_W'(t2i_pkg::MAX_SYMBOLS) : symbol_count;

    always_comb begin
        hit   = 1'b0;
        digit = '0;
        // Scan downward so the lowest matching position wins.
        for (int i = t2i_pkg::MAX_SYMBOLS - 1; i >= 0; i--) begin
            if ((t2i_pkg::COUNT_W'(i) < used) && (sym[i] == ch)) begin
                hit   = 1'b1;
                digit = t2i_pkg::DIGIT_W'(i);
            end
        end
    end

    always_comb begin
        bad = 1'b0;
        for (int i = 0; i < t2i_pkg::MAX_SYMBOLS; i++) begin
            if (t2i_pkg::COUNT_W'(i) < symbol_count) begin
                if ((sym[i] == '0) || (sym[i] == t2i_pkg::CH_PLUS) ||
                    (sym[i] == t2i_pkg::CH_MINUS) || t2i_pkg::is_space(sym[i])) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < t2i_pkg::MAX_SYMBOLS; j++) begin
                    if ((t2i_pkg::COUNT_W'(j) < symbol_count) && (sym[j] == sym[i])) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign ok = (symbol_count >= t2i_pkg::COUNT_W'(2)) &&
                (symbol_count <= t2i_pkg::COUNT_W'(t2i_pkg::MAX_SYMBOLS)) && !bad;

    assign result = {ok, hit, digit};

endmodule

// File: test/tb_text_to_integer_any_base_top.sv
module tb_text_to_integer_any_base_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The index after the last register; writes to it must leave the alphabet alone.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
    } parse_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] ch
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] value
    logic [0:0]  m_tuser;          // [0] alphabet_ok
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    text_to_integer_any_base_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Alphabet as the parser sees it, updated when a register write is accepted.
    logic [63:0] alpha_lo    = '0;
    logic [63:0] alpha_hi    = '0;
    logic [4:0]  alpha_count = '0;

    // Parser state mirrored by the predictor.
    logic [1:0]  p_phase = t2i_pkg::PH_SPACE;
    logic        p_neg   = 1'b0;
    logic [31:0] p_acc   = '0;

    char_word_t    pending_chars[$];
    parse_result_t expected_results[$];

    int  words_queued   = 0;
    int  words_taken    = 0;
    int  strings_queued = 0;
    int  results_seen   = 0;
    int  settings_run   = 0;
    int  error_count    = 0;
    int  s_gap          = 0;
    int  m_stall        = 0;
    bit  idle_on        = 1'b1;

    // Alphabet chosen by the stimulus, used to pick digits for the strings.
    logic [7:0] gen_sym [16];
    int         gen_n;

    function automatic bit blank_char(logic [7:0] c);
        return c == t2i_pkg::CH_SPACE || c == t2i_pkg::CH_NL || c == t2i_pkg::CH_TAB ||
               c == t2i_pkg::CH_VT || c == t2i_pkg::CH_CR || c == t2i_pkg::CH_FF;
    endfunction

    function automatic logic [7:0] alpha_sym(int i);
        if (i < 8) return alpha_lo[8*i +: 8];
        return alpha_hi[8*(i-8) +: 8];
    endfunction

    function automatic bit alphabet_good();
        logic [7:0] s;
        if (alpha_count < 2 || alpha_count > t2i_pkg::MAX_SYMBOLS) return 1'b0;
        for (int i = 0; i < alpha_count; i++) begin
            s = alpha_sym(i);
            if (s == 8'h00 || s == t2i_pkg::CH_PLUS || s == t2i_pkg::CH_MINUS ||
                blank_char(s)) return 1'b0;
            for (int j = i + 1; j < alpha_count; j++)
                if (alpha_sym(j) == s) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Lookup is capped at the symbol store even when the count is larger.
    function automatic int digit_index(logic [7:0] c);
        int n;
        n = (alpha_count > t2i_pkg::MAX_SYMBOLS) ? t2i_pkg::MAX_SYMBOLS : alpha_count;
        for (int i = 0; i < n; i++)
            if (alpha_sym(i) == c) return i;
        return -1;
    endfunction

    function automatic void parse_char(logic [7:0] c, logic last);
        int            d;
        parse_result_t r;
        if (p_phase == t2i_pkg::PH_SPACE && !blank_char(c)) p_phase = t2i_pkg::PH_SIGN;
        if (p_phase == t2i_pkg::PH_SIGN) begin
            if (c == t2i_pkg::CH_MINUS) p_neg = ~p_neg;
            else if (c != t2i_pkg::CH_PLUS) p_phase = t2i_pkg::PH_DIGIT;
        end
        if (p_phase == t2i_pkg::PH_DIGIT) begin
            d = digit_index(c);
            if (d < 0) p_phase = t2i_pkg::PH_STOP;
            else p_acc = p_acc * {27'd0, alpha_count} + d[31:0];
        end
        if (last) begin
            r.ok    = alphabet_good();
            r.value = !r.ok ? 32'd0 : (p_neg ? 32'd0 - p_acc : p_acc);
            expected_results.push_back(r);
            p_phase = t2i_pkg::PH_SPACE;
            p_neg   = 1'b0;
            p_acc   = '0;
        end
    endfunction

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endfunction

    // Character driver.
    always @(posedge aclk) begin
        char_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata, s_tlast);
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap != 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() != 0 && idle_on &&
                             $urandom_range(0, 7) == 0) begin
                    s_gap = $urandom_range(0, 12);
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    w = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= w.ch;
                    s_tlast  <= w.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        parse_result_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result word: value %0d ok %0b",
                                           $signed(m_tdata), m_tuser[0]));
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata !== e.value || m_tuser[0] !== e.ok)
                        report_error($sformatf(
                            "result %0d: expected value %0d ok %0b, got value %0d ok %0b",
                            results_seen, $signed(e.value), e.ok,
                            $signed(m_tdata), m_tuser[0]));
                end
            end
            if (m_stall != 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_stall = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_word(logic [7:0] c, logic last);
        pending_chars.push_back('{ch: c, last: last});
        words_queued++;
        if (last) strings_queued++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            t2i_pkg::REG_SYMBOLS_LOW:  alpha_lo    = data;
            t2i_pkg::REG_SYMBOLS_HIGH: alpha_hi    = data;
            t2i_pkg::REG_SYMBOL_COUNT: alpha_count = data[4:0];
            default: ;
        endcase
    endtask

    // Waits until every word is taken and every result is back, then lets the
    // pipeline settle before the alphabet may change.
    task automatic drain();
        do @(posedge aclk);
        while (words_taken != words_queued || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic bit usable_sym(logic [7:0] c);
        return c != 8'h00 && c != t2i_pkg::CH_PLUS && c != t2i_pkg::CH_MINUS &&
               !blank_char(c);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return t2i_pkg::CH_SPACE;
            1: return t2i_pkg::CH_NL;
            2: return t2i_pkg::CH_TAB;
            3: return t2i_pkg::CH_VT;
            4: return t2i_pkg::CH_CR;
            default: return t2i_pkg::CH_FF;
        endcase
    endfunction

    task automatic build_alphabet(int n, bit good);
        logic [7:0] c;
        bit         dup;
        int         i;
        for (i = 0; i < 16; i++) begin
            do begin
                c = 8'($urandom_range(1, 255));
                dup = 1'b0;
                for (int j = 0; j < i; j++)
                    if (gen_sym[j] == c) dup = 1'b1;
            end while (!usable_sym(c) || dup);
            gen_sym[i] = c;
        end
        gen_n = n;
        if (!good) begin
            case ($urandom_range(0, 4))
                0: begin
                    i = $urandom_range(1, n - 1);
                    gen_sym[i] = gen_sym[$urandom_range(0, i - 1)];
                end
                1: gen_sym[$urandom_range(0, n - 1)] = 8'h00;
                2: gen_sym[$urandom_range(0, n - 1)] =
                       $urandom_range(0, 1) ? t2i_pkg::CH_PLUS : t2i_pkg::CH_MINUS;
                3: gen_sym[$urandom_range(0, n - 1)] = pick_blank();
                default: gen_n = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                      : $urandom_range(17, 31);
            endcase
        end
    endtask

    task automatic load_alphabet();
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = gen_sym[i];
            hi[8*i +: 8] = gen_sym[i+8];
        end
        if ($urandom_range(0, 1)) write_reg(t2i_pkg::REG_SYMBOL_COUNT, 64'(gen_n[4:0]));
        write_reg(t2i_pkg::REG_SYMBOLS_LOW, lo);
        write_reg(t2i_pkg::REG_SYMBOLS_HIGH, hi);
        write_reg(t2i_pkg::REG_SYMBOL_COUNT, 64'(gen_n[4:0]));
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    // Mostly well-formed strings: blanks, a sign run, digits, and an optional
    // tail of random bytes. The rest is raw noise.
    task automatic send_string();
        logic [7:0] str[$];
        int         used;
        used = (gen_n > 16) ? 16 : gen_n;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) str.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) str.push_back(pick_blank());
            repeat ($urandom_range(0, 3))
                str.push_back($urandom_range(0, 1) ? t2i_pkg::CH_MINUS : t2i_pkg::CH_PLUS);
            repeat (($urandom_range(0, 5) == 0) ? $urandom_range(9, 14)
                                                : $urandom_range(1, 6))
                str.push_back(used > 0 ? gen_sym[$urandom_range(0, used - 1)]
                                       : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) str.push_back(8'($urandom_range(0, 255)));
        end
        foreach (str[i]) push_word(str[i], i == str.size() - 1);
    endtask

    initial begin
        int phase_start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the reset alphabet the count is zero, so any result is invalid.
        push_word(8'h35, 1'b1);
        drain();

        // Decimal alphabet, then a write to the unused index that must change nothing.
        for (int i = 0; i < 16; i++) gen_sym[i] = 8'((i < 10) ? 8'h30 + i : 8'h57 + i);
        gen_n = 10;
        load_alphabet();
        write_reg(REG_UNUSED, '1);
        push_word(t2i_pkg::CH_TAB, 1'b0);
        push_word(t2i_pkg::CH_VT, 1'b0);
        push_word(t2i_pkg::CH_FF, 1'b0);
        push_word(t2i_pkg::CH_CR, 1'b0);
        push_word(t2i_pkg::CH_NL, 1'b0);
        push_word(t2i_pkg::CH_SPACE, 1'b0);
        push_word(t2i_pkg::CH_MINUS, 1'b0);
        push_word(t2i_pkg::CH_PLUS, 1'b0);
        push_word(8'h35, 1'b1);
        // Ten nines overflow 32 bits and must wrap.
        for (int i = 0; i < 10; i++) push_word(8'h39, i == 9);
        // A zero byte stops the digits.
        push_word(8'h31, 1'b0);
        push_word(8'h00, 1'b1);
        push_word(8'hFF, 1'b1);
        push_word(t2i_pkg::CH_MINUS, 1'b1);
        drain();

        for (int s = 0; s < 14; s++) begin
            idle_on = (s < 12) && (s % 5 != 4);
            case (s)
                0: build_alphabet(2, 1'b1);
                1: build_alphabet(16, 1'b1);
                2: begin
                    foreach (gen_sym[i]) gen_sym[i] = 8'hFF;
                    gen_n = 16;
                end
                3: begin
                    foreach (gen_sym[i]) gen_sym[i] = 8'h00;
                    gen_n = 31;
                end
                default: build_alphabet($urandom_range(2, 16), $urandom_range(0, 3) != 0);
            endcase
            load_alphabet();
            phase_start = words_queued;
            while (words_queued - phase_start < 55) send_string();
            drain();
            settings_run++;
        end

        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        $display("Ran %0d characters in %0d strings over %0d random alphabet settings,",
                 words_taken, strings_queued, settings_run);
        $display("checked %0d results, %0d errors.", results_seen, error_count);
        if (error_count == 0) begin
            $display("tb_text_to_integer_any_base_top: clean");
        end else begin
            $display("tb_text_to_integer_any_base_top: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_text_to_integer_any_base_top: errors");
        $finish;
    end

endmodule
